// ----- src/tlvp_pkg.sv -----
// Shared types and constants of the record stream parser.
package tlvp_pkg;

  // Width that name, value and total lengths are kept in.
  localparam int LENGTH_BITS = 32;
  // Width of the element count and of the element index.
  localparam int COUNT_BITS  = 32;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX   = {LENGTH_BITS{1'b1}};
  // Every length and count field of the format is four bytes long.
  localparam logic [LENGTH_BITS-1:0] HDR_BYTES = LENGTH_BITS'(4);

  // Parse phase; its codes double as the byte role of a result.
  typedef enum logic [2:0] {
    PH_TOTAL     = 3'd0,
    PH_COUNT     = 3'd1,
    PH_TYPE      = 3'd2,
    PH_NAME_LEN  = 3'd3,
    PH_NAME      = 3'd4,
    PH_VALUE_LEN = 3'd5,
    PH_VALUE     = 3'd6,
    PH_EXCESS    = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_EXTRA     = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  typedef struct packed {
    phase_t                  phase;
    logic [LENGTH_BITS-1:0]  field_cnt;
    logic [LENGTH_BITS-1:0]  len_acc;
    logic [LENGTH_BITS-1:0]  decl_len;
    logic [COUNT_BITS-1:0]   decl_cnt;
    logic [COUNT_BITS-1:0]   elem_done;
    logic [LENGTH_BITS-1:0]  bytes_seen;
    logic [7:0]              cur_type;
    status_t                 status;
  } parse_state_t;

  typedef struct packed {
    phase_t                 role;
    logic [COUNT_BITS-1:0]  index;
    logic                   elem_end;
    logic                   buf_end;
    status_t                status;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:      PH_TOTAL,
    field_cnt:  '0,
    len_acc:    '0,
    decl_len:   '0,
    decl_cnt:   '0,
    elem_done:  '0,
    bytes_seen: '0,
    cur_type:   '0,
    status:     ST_OK
  };

endpackage

// ----- src/tlv_record_stream_parser.sv -----
// Top level of the record stream parser: input register, parse state and result register.
// A byte's result passes the input register and then the result register, and the parse state
// is updated when the result register is loaded.
// Throughput: one byte per cycle while the result side is not stalled; the only loop is the parse state update.
// Reset: rst is synchronous and active high; it empties both registers and returns the
// parse state to the total length phase. The state also returns there after each last byte.
module tlv_record_stream_parser import tlvp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Request side.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // buffer_last
  // Result side.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] element_index, [32] element_end,
                                      // [35:33] parse_status, [39:36] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] byte_role
  output logic        m_axis_tlast    // buffer_end
);

  // Input register: holds one request until the parse step can take it.
  logic        in_valid;
  logic [7:0]  in_byte_q;
  logic        in_last_q;

  // Parse state, updated once per processed byte.
  parse_state_t st;
  parse_state_t st_next;

  // Result register.
  logic    out_valid;
  result_t out_res;
  result_t step_res;

  logic fire;

  // A byte moves through the step when the result register is empty or is being drained
  // in this cycle. While a finished result waits, a new request is taken only into an empty input register.
  assign fire          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;

  tlvp_step u_step (
    .cur     (st),
    .in_byte (in_byte_q),
    .in_last (in_last_q),
    .nxt     (st_next),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_res.status, out_res.elem_end, out_res.index};
  assign m_axis_tuser  = out_res.role;
  assign m_axis_tlast  = out_res.buf_end;

  // An element can only be completed by a name length, name, value length or value byte.
  a_end_role: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[32] |->
      (m_axis_tuser == PH_NAME_LEN) || (m_axis_tuser == PH_NAME) ||
      (m_axis_tuser == PH_VALUE_LEN) || (m_axis_tuser == PH_VALUE))
    else $error("element end on a byte that cannot close an element");

  // Header bytes belong to no element.
  a_header_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == PH_TOTAL || m_axis_tuser == PH_COUNT) |->
      (m_axis_tdata[31:0] == '0) && !m_axis_tdata[32])
    else $error("header byte reported with an element index or end");

  // The last byte of a buffer leaves the parser in its reset state.
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    fire && in_last_q |=> (st == STATE_RESET))
    else $error("parse state not cleared after the last byte");

  // A held error survives every byte that is not the last one.
  a_status_sticky: assert property (@(posedge clk) disable iff (rst)
    fire && !in_last_q && (st.status != ST_OK) |=> (st.status == $past(st.status)))
    else $error("sticky status changed within a buffer");

endmodule

// ----- src/tlvp_step.sv -----
// Next-state and result logic of the parser for one buffer byte.
module tlvp_step import tlvp_pkg::*; (
  input  parse_state_t cur,
  input  logic [7:0]   in_byte,
  input  logic         in_last,
  output parse_state_t nxt,
  output result_t      res
);

  localparam logic [7:0] TYPE_A = 8'h41;
  localparam logic [7:0] TYPE_B = 8'h42;
  localparam logic [7:0] TYPE_C = 8'h43;
  localparam logic [7:0] TYPE_D = 8'h44;
  localparam logic [7:0] TYPE_E = 8'h45;
  localparam logic [7:0] TYPE_F = 8'h46;
  localparam logic [7:0] TYPE_G = 8'h47;
  localparam logic [7:0] TYPE_H = 8'h48;
  localparam logic [7:0] TYPE_I = 8'h49;
  localparam logic [7:0] TYPE_J = 8'h4A;
  localparam logic [7:0] TYPE_K = 8'h4B;
  localparam logic [7:0] TYPE_L = 8'h4C;
  localparam logic [7:0] TYPE_M = 8'h4D;

  function automatic logic [LENGTH_BITS-1:0] shift_len(input logic [LENGTH_BITS-1:0] acc,
                                                       input logic [7:0] b);
    return {acc[LENGTH_BITS-9:0], b};
  endfunction

  function automatic logic is_variable(input logic [7:0] t);
    return (t == TYPE_B) || (t == TYPE_K) || (t == TYPE_L) || (t == TYPE_M);
  endfunction

  function automatic logic [3:0] fixed_size(input logic [7:0] t);
    logic [3:0] sz;
    if (t == TYPE_A || t == TYPE_C || t == TYPE_G) begin
      sz = 4'd1;
    end else if (t == TYPE_D || t == TYPE_H) begin
      sz = 4'd2;
    end else if (t == TYPE_E || t == TYPE_I) begin
      sz = 4'd4;
    end else if (t == TYPE_F || t == TYPE_J) begin
      sz = 4'd8;
    end else begin
      sz = 4'd0;
    end
    return sz;
  endfunction

  logic [LENGTH_BITS-1:0] field_inc;
  logic [LENGTH_BITS-1:0] len_shifted;
  logic [COUNT_BITS-1:0]  cnt_shifted;
  logic [COUNT_BITS-1:0]  done_inc;
  logic [3:0]             sz;
  logic                   do_after;
  logic                   do_finish;
  logic                   elem_end;
  parse_state_t           upd;

  assign field_inc   = cur.field_cnt + LENGTH_BITS'(1);
  assign len_shifted = shift_len(cur.len_acc, in_byte);
  assign cnt_shifted = {cur.decl_cnt[COUNT_BITS-9:0], in_byte};
  assign done_inc    = cur.elem_done + COUNT_BITS'(1);
  assign sz          = fixed_size(cur.cur_type);

  always_comb begin
    upd       = cur;
    do_after  = 1'b0;
    do_finish = 1'b0;
    elem_end  = 1'b0;

    if (cur.bytes_seen != LEN_MAX) begin
      upd.bytes_seen = cur.bytes_seen + LENGTH_BITS'(1);
    end

    unique case (cur.phase)
      PH_TOTAL: begin
        upd.decl_len = shift_len(cur.decl_len, in_byte);
        if (field_inc == HDR_BYTES) begin
          upd.field_cnt = '0;
          upd.phase     = PH_COUNT;
        end else begin
          upd.field_cnt = field_inc;
        end
      end
      PH_COUNT: begin
        upd.decl_cnt = cnt_shifted;
        if (field_inc == HDR_BYTES) begin
          upd.field_cnt = '0;
          upd.phase     = (cnt_shifted == '0) ? PH_EXCESS : PH_TYPE;
        end else begin
          upd.field_cnt = field_inc;
        end
      end
      PH_TYPE: begin
        upd.cur_type  = in_byte;
        if ((in_byte < TYPE_A || in_byte > TYPE_M) && cur.status == ST_OK) begin
          upd.status = ST_BAD_TYPE;
        end
        upd.field_cnt = '0;
        upd.len_acc   = '0;
        upd.phase     = PH_NAME_LEN;
      end
      PH_NAME_LEN: begin
        upd.len_acc = len_shifted;
        if (field_inc == HDR_BYTES) begin
          upd.field_cnt = '0;
          if (len_shifted == '0) begin
            do_after = 1'b1;
          end else begin
            upd.phase = PH_NAME;
          end
        end else begin
          upd.field_cnt = field_inc;
        end
      end
      PH_NAME: begin
        upd.field_cnt = field_inc;
        if (field_inc >= cur.len_acc) begin
          do_after = 1'b1;
        end
      end
      PH_VALUE_LEN: begin
        upd.len_acc = len_shifted;
        if (field_inc == HDR_BYTES) begin
          upd.field_cnt = '0;
          if (len_shifted == '0) begin
            do_finish = 1'b1;
          end else begin
            upd.phase = PH_VALUE;
          end
        end else begin
          upd.field_cnt = field_inc;
        end
      end
      PH_VALUE: begin
        upd.field_cnt = field_inc;
        if (field_inc >= cur.len_acc) begin
          do_finish = 1'b1;
        end
      end
      PH_EXCESS: begin
        if (cur.status == ST_OK) begin
          upd.status = ST_EXTRA;
        end
      end
      default: begin
        upd = cur;
      end
    endcase

    // End of the name: either a value length follows, a fixed value
    // follows, or an unknown type closes the element right here.
    if (do_after) begin
      upd.field_cnt = '0;
      if (is_variable(cur.cur_type)) begin
        upd.len_acc = '0;
        upd.phase   = PH_VALUE_LEN;
      end else if (sz == 4'd0) begin
        do_finish = 1'b1;
      end else begin
        upd.len_acc = LENGTH_BITS'(sz);
        upd.phase   = PH_VALUE;
      end
    end

    if (do_finish) begin
      elem_end      = 1'b1;
      upd.elem_done = done_inc;
      upd.field_cnt = '0;
      upd.len_acc   = '0;
      upd.phase     = (done_inc == cur.decl_cnt) ? PH_EXCESS : PH_TYPE;
    end

    // Final verdict on the last byte, unless an error is already held.
    if (in_last && upd.status == ST_OK) begin
      if (upd.phase == PH_TOTAL || upd.phase == PH_COUNT) begin
        upd.status = ST_TRUNCATED;
      end else if (upd.bytes_seen != upd.decl_len) begin
        upd.status = ST_MISMATCH;
      end else if (upd.phase != PH_EXCESS) begin
        upd.status = ST_TRUNCATED;
      end
    end

    res.role     = cur.phase;
    res.index    = (cur.phase == PH_TOTAL || cur.phase == PH_COUNT) ? '0 : cur.elem_done;
    res.elem_end = elem_end;
    res.buf_end  = in_last;
    res.status   = upd.status;

    nxt = in_last ? STATE_RESET : upd;
  end

endmodule
